// ===== rtl/core/rrc_pkg.sv =====
package rrc_pkg;

   // Reserved table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   localparam int ADDR_W = 64;
   localparam logic [ADDR_W-1:0] PAGE_MASK = 64'h0000_0000_0000_0FFF;

   // One reserved interval [low, high)
   typedef struct packed {
      logic [ADDR_W-1:0] low;
      logic [ADDR_W-1:0] high;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== rtl/core/rrc_ram.sv =====
module rrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/reserved_range_carver_core.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  mode, start_address, size_bytes
// rsp_      out        rsp_valid / rsp_ready  piece_base, piece_length, last_piece
//
// Reserve: entries whose low is above the new low shift up one slot, then the entry is written;
//   the single-port-read table RAM, read one entry ahead, sets the pace.
// Carve: walks the stored entries in order; a piece waits in a pending register so the
//   last can be flagged; a new piece with one pending halts the walk while rsp_ is full.
// Zero-size or table-full reservations are dropped in the accept cycle.
// Synchronous reset clears the entry count and control; table contents need no clear.
module reserved_range_carver_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [63:0] req_start_address,
   input  logic [63:0] req_size_bytes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_piece_base,
   output logic [63:0] rsp_piece_length,
   output logic        rsp_last_piece
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SHIFT  = 3'd1;
   localparam logic [2:0] ST_INSERT = 3'd2;
   localparam logic [2:0] ST_CARVE  = 3'd3;
   localparam logic [2:0] ST_TAIL   = 3'd4;
   localparam logic [2:0] ST_LAST   = 3'd5;

   localparam int AW = rrc_pkg::ADDR_W;
   localparam int CW = rrc_pkg::COUNT_W;
   localparam int IW = rrc_pkg::IDX_W;

   // control state
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pos_ff, pos_in;       // insertion slot / carve entry index
   logic          pend_valid_ff, pend_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [AW-1:0] base_ff, base_in;     // carve start, or page-aligned reserve low
   logic [AW-1:0] end_ff, end_in;       // start + size, wrapping
   logic [AW-1:0] cursor_ff, cursor_in;
   logic [AW-1:0] pend_base_ff, pend_base_in;
   logic [AW-1:0] pend_len_ff, pend_len_in;
   logic [AW-1:0] rsp_base_ff, rsp_base_in;
   logic [AW-1:0] rsp_len_ff, rsp_len_in;
   logic          rsp_last_ff, rsp_last_in;

   // table RAM port
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   rrc_pkg::entry_type   wr_entry;
   logic [IW-1:0]        rd_addr;
   rrc_pkg::entry_type   rd_entry;

   logic                 accept;
   logic                 out_free;
   rrc_pkg::entry_type   new_entry;
   logic [AW-1:0]        rb, re;
   logic                 hit, piece, tail;
   logic [CW-1:0]        pos_next;

   rrc_ram #(
      .WIDTH (rrc_pkg::ENTRY_W),
      .DEPTH (rrc_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   // output register can take a new piece this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // new reservation: high is rounded up only when it is written
   assign new_entry.low  = base_ff;
   assign new_entry.high = (end_ff + rrc_pkg::PAGE_MASK) & ~rrc_pkg::PAGE_MASK;

   // carve: clip the entry being read to [start, end)
   assign rb    = (rd_entry.low > base_ff) ? rd_entry.low : base_ff;
   assign re    = (rd_entry.high < end_ff) ? rd_entry.high : end_ff;
   assign hit   = rb < re;
   assign piece = hit && (cursor_ff < rb);
   assign tail  = cursor_ff < end_ff;

   assign pos_next = pos_ff + CW'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      pend_valid_in = pend_valid_ff;
      base_in       = base_ff;
      end_in        = end_ff;
      cursor_in     = cursor_ff;
      pend_base_in  = pend_base_ff;
      pend_len_in   = pend_len_ff;
      rsp_base_in   = rsp_base_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      wr_en         = 1'b0;
      wr_addr       = pos_ff[IW-1:0];
      wr_entry      = new_entry;
      rd_addr       = '0;

      case (state_ff)
         ST_IDLE: begin
            // prefetch: last entry for an insert, first entry for a carve
            rd_addr = req_mode ? '0 : IW'(count_ff - CW'(1));
            if (accept) begin
               end_in = req_start_address + req_size_bytes;
               if (req_mode) begin
                  base_in       = req_start_address;
                  cursor_in     = req_start_address;
                  pos_in        = '0;
                  pend_valid_in = 1'b0;
                  state_in      = (count_ff == '0) ? ST_TAIL : ST_CARVE;
               end else if (req_size_bytes != '0 &&
                            count_ff < CW'(rrc_pkg::TABLE_DEPTH)) begin
                  base_in  = req_start_address & ~rrc_pkg::PAGE_MASK;
                  pos_in   = count_ff;
                  state_in = (count_ff == '0) ? ST_INSERT : ST_SHIFT;
               end
            end
         end

         ST_SHIFT: begin
            // rd_entry holds entry pos-1
            rd_addr = IW'(pos_ff - CW'(2));
            if (rd_entry.low > base_ff) begin
               wr_en    = 1'b1;
               wr_entry = rd_entry;
               pos_in   = pos_ff - CW'(1);
               if (pos_ff == CW'(1)) begin
                  state_in = ST_INSERT;
               end
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = ST_IDLE;
            end
         end

         ST_INSERT: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
            state_in = ST_IDLE;
         end

         ST_CARVE: begin
            if (piece && pend_valid_ff && !out_free) begin
               // hold and re-read the same entry
               rd_addr = pos_ff[IW-1:0];
            end else begin
               rd_addr = pos_next[IW-1:0];
               if (piece) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_base_in  = pend_base_ff;
                     rsp_len_in   = pend_len_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_base_in  = cursor_ff;
                  pend_len_in   = rb - cursor_ff;
               end
               if (hit && re > cursor_ff) begin
                  cursor_in = re;
               end
               pos_in = pos_next;
               if (pos_next == count_ff) begin
                  state_in = ST_TAIL;
               end
            end
         end

         ST_TAIL: begin
            if (!(tail && pend_valid_ff && !out_free)) begin
               if (tail) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_base_in  = pend_base_ff;
                     rsp_len_in   = pend_len_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_base_in  = cursor_ff;
                  pend_len_in   = end_ff - cursor_ff;
               end
               state_in = ST_LAST;
            end
         end

         ST_LAST: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_base_in   = pend_base_ff;
               rsp_len_in    = pend_len_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pos_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pos_ff        <= pos_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      end_ff       <= end_in;
      cursor_ff    <= cursor_in;
      pend_base_ff <= pend_base_in;
      pend_len_ff  <= pend_len_in;
      rsp_base_ff  <= rsp_base_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_piece_base   = rsp_base_ff;
   assign rsp_piece_length = rsp_len_ff;
   assign rsp_last_piece   = rsp_last_ff;

endmodule
